// ===== rtl/oram_tree_path_address_gen_core_defines.svh =====
// ----------------------------------------------------------------------------
// ORAM tree path address generator: assertion macros
// Concurrent checks on clock, synchronous reset masks each check.
// ----------------------------------------------------------------------------
`ifndef ORAM_TREE_PATH_ADDRESS_GEN_CORE_DEFINES_SVH
`define ORAM_TREE_PATH_ADDRESS_GEN_CORE_DEFINES_SVH

// same-cycle implication
`define OTPAG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OTPAG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/otpag_pkg.sv =====
// ----------------------------------------------------------------------------
// otpag_pkg
// Widths, register indexes, reset values and shared types of the
// ORAM tree path address generator.
// ----------------------------------------------------------------------------
package otpag_pkg;

   localparam int ADDR_W   = 48;
   localparam int PATH_W   = 32;
   localparam int LVL_W    = 6;
   localparam int LVLO_W   = 5;
   localparam int BKT_W    = 17;
   localparam int PAGE_W   = 21;
   localparam int BASE_W   = 40;
   localparam int LPP_W    = 5;
   localparam int CIDX_W   = 3;
   localparam int CDAT_W   = 40;
   localparam int MUL_W    = PATH_W + PAGE_W;
   localparam int SH_W     = BKT_W + PAGE_W;

   localparam logic [LVL_W-1:0] LEVELS_MAX = 6'd32;

   localparam logic [CIDX_W-1:0] CSR_LAYOUT_MODE  = 3'd0;
   localparam logic [CIDX_W-1:0] CSR_TREE_LEVELS  = 3'd1;
   localparam logic [CIDX_W-1:0] CSR_BUCKET_BYTES = 3'd2;
   localparam logic [CIDX_W-1:0] CSR_PAGE_BYTES   = 3'd3;
   localparam logic [CIDX_W-1:0] CSR_BASE_OFFSET  = 3'd4;

   localparam logic [LVL_W-1:0]  RST_LEVELS = 6'd16;
   localparam logic [BKT_W-1:0]  RST_BUCKET = 17'd64;
   localparam logic [PAGE_W-1:0] RST_PAGE   = 21'd4096;
   localparam logic [BASE_W-1:0] RST_BASE   = '0;
   // 4096 / 64 = 64 buckets per page: 6 levels per page, 16 mod 6 on top
   localparam logic [LPP_W-1:0]  RST_LPP    = 5'd6;
   localparam logic [LVL_W-1:0]  RST_TOP    = 6'd4;

   typedef struct packed {
      logic              mode;
      logic [LVL_W-1:0]  levels;
      logic [BKT_W-1:0]  bucket;
      logic [PAGE_W-1:0] page;
      logic [BASE_W-1:0] base;
      logic [LPP_W-1:0]  lpp;
      logic [LVL_W-1:0]  top;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic              row_mul;
      logic              row_add;
      logic              emit;
      logic              last;
      logic [LVLO_W-1:0] level;
      logic [LVLO_W-1:0] shamt;
      logic [LVLO_W-1:0] bit_sel;
   } ctl_type;

   function automatic logic [LVL_W-1:0] eff_levels(input logic [LVL_W-1:0] v);
      logic [LVL_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 6'd1;
      end else if (v > LEVELS_MAX) begin
         r = LEVELS_MAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/oram_tree_path_address_gen_core.sv =====
// ----------------------------------------------------------------------------
// oram_tree_path_address_gen_core
// Path ORAM bucket address generator: one leaf path in, one bucket address
// per tree level out, root first, plain heap or paged layout.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  req       start / busy          req_leaf_path, req_access_kind
//  rsp       rsp_valid (strobe)    rsp_bucket_address, rsp_tree_level,
//                                  rsp_access_type_out, rsp_last_of_path
//  csr       csr_valid / csr_ready csr_index, csr_wdata
//
//  Busy holds after a transfer through the load state, each level's emit
//  state and, in paged layout, a multiply and an add state per page row
//  below the top page; the next transfer can follow at once. The first
//  result is registered after the load and emit states; results cannot
//  stall. A register write rederives the page split (shift-compare of
//  bucket vs page size, then repeated subtract); reset presets both.
// ----------------------------------------------------------------------------
`include "oram_tree_path_address_gen_core_defines.svh"

module oram_tree_path_address_gen_core
   import otpag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [PATH_W-1:0] req_leaf_path,
   input  logic              req_access_kind,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_bucket_address,
   output logic [LVLO_W-1:0] rsp_tree_level,
   output logic              rsp_access_type_out,
   output logic              rsp_last_of_path,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CDAT_W-1:0] csr_wdata
);

   cfg_type cfg;
   ctl_type ctl;
   logic    seq_busy;
   logic    cfg_busy;
   logic    start_acc;

   assign busy      = seq_busy || cfg_busy;
   assign start_acc = start && !busy;

   otpag_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .seq_busy  (seq_busy),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cfg_busy  (cfg_busy)
   );

   otpag_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start_acc (start_acc),
      .cfg       (cfg),
      .ctl       (ctl),
      .seq_busy  (seq_busy)
   );

   otpag_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .start_acc           (start_acc),
      .req_leaf_path       (req_leaf_path),
      .req_access_kind     (req_access_kind),
      .cfg                 (cfg),
      .ctl                 (ctl),
      .rsp_valid           (rsp_valid),
      .rsp_bucket_address  (rsp_bucket_address),
      .rsp_tree_level      (rsp_tree_level),
      .rsp_access_type_out (rsp_access_type_out),
      .rsp_last_of_path    (rsp_last_of_path)
   );

   `OTPAG_ASSERT_NEXT(a_leaf_ends, rsp_valid && rsp_last_of_path, !rsp_valid, "strobe after leaf")
   `OTPAG_ASSERT_NOW(a_mid_path_busy, rsp_valid && !rsp_last_of_path, busy, "idle mid path")
   `OTPAG_ASSERT_NEXT(a_start_busy, start && !busy, busy && !rsp_valid, "no walk after transfer")

endmodule

// ===== rtl/otpag_cfg.sv =====
// ----------------------------------------------------------------------------
// otpag_cfg
// Configuration registers and the iterative derivation of levels per page
// (shift-compare) and levels in the top page (repeated subtract).
// ----------------------------------------------------------------------------
module otpag_cfg
   import otpag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              seq_busy,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CDAT_W-1:0] csr_wdata,
   output cfg_type           cfg,
   output logic              cfg_busy
);

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_INIT = 4'b0010,
      D_LPP  = 4'b0100,
      D_TOP  = 4'b1000
   } dstate_type;

   dstate_type        state_ff, state_in;
   logic              mode_ff, mode_in;
   logic [LVL_W-1:0]  levels_ff, levels_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [LPP_W-1:0]  lpp_ff, lpp_in;
   logic [LVL_W-1:0]  top_ff, top_in;
   logic [SH_W-1:0]   sh_ff, sh_in;
   logic [LPP_W-1:0]  k_ff, k_in;
   logic              wr;
   logic [BKT_W-1:0]  bsz;

   assign cfg_busy  = (state_ff != D_IDLE);
   assign csr_ready = !seq_busy && !cfg_busy && !start;
   assign wr        = csr_valid && csr_ready;
   assign bsz       = (bucket_ff == '0) ? 17'd1 : bucket_ff;

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      levels_in = levels_ff;
      bucket_in = bucket_ff;
      page_in   = page_ff;
      base_in   = base_ff;
      lpp_in    = lpp_ff;
      top_in    = top_ff;
      sh_in     = sh_ff;
      k_in      = k_ff;
      case (state_ff)
         D_IDLE: begin
            if (wr) begin
               state_in = D_INIT;
               case (csr_index)
                  CSR_LAYOUT_MODE:  mode_in   = csr_wdata[0];
                  CSR_TREE_LEVELS:  levels_in = eff_levels(csr_wdata[LVL_W-1:0]);
                  CSR_BUCKET_BYTES: bucket_in = csr_wdata[BKT_W-1:0];
                  CSR_PAGE_BYTES:   page_in   = csr_wdata[PAGE_W-1:0];
                  CSR_BASE_OFFSET:  base_in   = csr_wdata[BASE_W-1:0];
                  default:          state_in  = D_IDLE;
               endcase
            end
         end
         D_INIT: begin
            sh_in    = {{(SH_W-BKT_W-1){1'b0}}, bsz, 1'b0};
            k_in     = 5'd1;
            lpp_in   = 5'd1;
            state_in = D_LPP;
         end
         D_LPP: begin
            if (sh_ff <= {{(SH_W-PAGE_W){1'b0}}, page_ff}) begin
               lpp_in = k_ff;
               k_in   = k_ff + 5'd1;
               sh_in  = {sh_ff[SH_W-2:0], 1'b0};
            end else begin
               top_in   = levels_ff;
               state_in = D_TOP;
            end
         end
         D_TOP: begin
            if (top_ff > {1'b0, lpp_ff}) begin
               top_in = top_ff - {1'b0, lpp_ff};
            end else begin
               state_in = D_IDLE;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= D_IDLE;
         mode_ff   <= 1'b0;
         levels_ff <= RST_LEVELS;
         bucket_ff <= RST_BUCKET;
         page_ff   <= RST_PAGE;
         base_ff   <= RST_BASE;
         lpp_ff    <= RST_LPP;
         top_ff    <= RST_TOP;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         levels_ff <= levels_in;
         bucket_ff <= bucket_in;
         page_ff   <= page_in;
         base_ff   <= base_in;
         lpp_ff    <= lpp_in;
         top_ff    <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      k_ff  <= k_in;
   end

   assign cfg.mode   = mode_ff;
   assign cfg.levels = levels_ff;
   assign cfg.bucket = bucket_ff;
   assign cfg.page   = page_ff;
   assign cfg.base   = base_ff;
   assign cfg.lpp    = lpp_ff;
   assign cfg.top    = top_ff;

endmodule

// ===== rtl/otpag_seq.sv =====
// ----------------------------------------------------------------------------
// otpag_seq
// Level sequencer: walks root to leaf, one level per emit cycle, and
// inserts, in paged layout, a multiply and an add state at each page row start.
// ----------------------------------------------------------------------------
module otpag_seq
   import otpag_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start_acc,
   input  cfg_type cfg,
   output ctl_type ctl,
   output logic    seq_busy
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_LOAD    = 5'b00010,
      S_EMIT    = 5'b00100,
      S_ROW_MUL = 5'b01000,
      S_ROW_ADD = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [LVLO_W-1:0] level_ff, level_in;
   logic [LVL_W-1:0]  seg_ff, seg_in;
   logic [LVL_W-1:0]  shamt_full;
   logic [LVL_W-1:0]  bit_full;
   logic              last;

   assign shamt_full = cfg.levels - 6'd1 - {1'b0, level_ff};
   assign bit_full   = shamt_full - 6'd1;
   assign last       = ({1'b0, level_ff} == (cfg.levels - 6'd1));

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      seg_in   = seg_ff;
      case (state_ff)
         S_IDLE: begin
            if (start_acc) begin
               state_in = S_LOAD;
               level_in = '0;
               seg_in   = cfg.top;
            end
         end
         S_LOAD: state_in = S_EMIT;
         S_EMIT: begin
            if (last) begin
               state_in = S_IDLE;
            end else begin
               level_in = level_ff + 5'd1;
               seg_in   = seg_ff - 6'd1;
               if (cfg.mode && (seg_ff == 6'd1)) begin
                  state_in = S_ROW_MUL;
                  seg_in   = {1'b0, cfg.lpp};
               end
            end
         end
         S_ROW_MUL: state_in = S_ROW_ADD;
         S_ROW_ADD: state_in = S_EMIT;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= '0;
         seg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         seg_ff   <= seg_in;
      end
   end

   assign seq_busy    = (state_ff != S_IDLE);
   assign ctl.load    = (state_ff == S_LOAD);
   assign ctl.row_mul = (state_ff == S_ROW_MUL);
   assign ctl.row_add = (state_ff == S_ROW_ADD);
   assign ctl.emit    = (state_ff == S_EMIT);
   assign ctl.last    = last;
   assign ctl.level   = level_ff;
   assign ctl.shamt   = shamt_full[LVLO_W-1:0];
   assign ctl.bit_sel = bit_full[LVLO_W-1:0];

endmodule

// ===== rtl/otpag_dp.sv =====
// ----------------------------------------------------------------------------
// otpag_dp
// Address datapath: one shared multiplier for the root and page row
// offsets, a doubling accumulator for the heap index times bucket size.
// ----------------------------------------------------------------------------
module otpag_dp
   import otpag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start_acc,
   input  logic [PATH_W-1:0] req_leaf_path,
   input  logic              req_access_kind,
   input  cfg_type           cfg,
   input  ctl_type           ctl,
   output logic              rsp_valid,
   output logic [ADDR_W-1:0] rsp_bucket_address,
   output logic [LVLO_W-1:0] rsp_tree_level,
   output logic              rsp_access_type_out,
   output logic              rsp_last_of_path
);

   logic [PATH_W-1:0] path_ff;
   logic              kind_ff;
   logic [ADDR_W-1:0] rel_ff, rel_in;
   logic [ADDR_W-1:0] sum_ff, sum_in;
   logic [ADDR_W-1:0] pb_ff, pb_in;
   logic [ADDR_W-1:0] prod_ff;
   logic              valid_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LVLO_W-1:0] level_ff;
   logic              kout_ff;
   logic              last_ff;

   logic [PATH_W-1:0] prefix;
   logic [PAGE_W-1:0] opb;
   logic [MUL_W-1:0]  mul_full;
   logic [ADDR_W-1:0] inc;
   logic [ADDR_W-1:0] page_sh;
   logic              pbit;

   assign prefix   = path_ff >> ctl.shamt;
   assign opb      = ctl.row_mul ? cfg.page : {{(PAGE_W-BKT_W){1'b0}}, cfg.bucket};
   assign mul_full = {{PAGE_W{1'b0}}, prefix} * {{PATH_W{1'b0}}, opb};
   assign pbit     = path_ff[ctl.bit_sel];
   assign inc      = pbit ? {{(ADDR_W-BKT_W-1){1'b0}}, cfg.bucket, 1'b0}
                          : {{(ADDR_W-BKT_W){1'b0}}, cfg.bucket};
   assign page_sh  = {{(ADDR_W-PAGE_W){1'b0}}, cfg.page} << ctl.level;

   always_comb begin
      rel_in = rel_ff;
      sum_in = sum_ff;
      pb_in  = pb_ff;
      if (ctl.load) begin
         rel_in = mul_full[ADDR_W-1:0];
         sum_in = {{(ADDR_W-BASE_W){1'b0}}, cfg.base};
         pb_in  = {{(ADDR_W-BASE_W){1'b0}}, cfg.base}
                + {{(ADDR_W-PAGE_W){1'b0}}, cfg.page};
      end else if (ctl.row_add) begin
         rel_in = '0;
         sum_in = prod_ff + pb_ff;
         pb_in  = pb_ff + page_sh;
      end else if (ctl.emit) begin
         rel_in = {rel_ff[ADDR_W-2:0], 1'b0} + inc;
      end
   end

   always_ff @(posedge clock) begin
      if (start_acc) begin
         path_ff <= req_leaf_path;
         kind_ff <= req_access_kind;
      end
      if (ctl.row_mul) begin
         prod_ff <= mul_full[ADDR_W-1:0];
      end
      rel_ff <= rel_in;
      sum_ff <= sum_in;
      pb_ff  <= pb_in;
      if (ctl.emit) begin
         addr_ff  <= rel_ff + sum_ff;
         level_ff <= ctl.level;
         kout_ff  <= kind_ff;
         last_ff  <= ctl.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.emit;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_bucket_address  = addr_ff;
   assign rsp_tree_level      = level_ff;
   assign rsp_access_type_out = kout_ff;
   assign rsp_last_of_path    = last_ff;

endmodule
